>>> sv/lsf_pkg.sv
`timescale 1ns / 1ps
// Shared types, codes and helper function of the line substring filter.
// No dependencies; every other file of the block but lsf_ifs imports this package.
package lsf_pkg;

  localparam logic [7:0] NEWLINE = 8'h0A;
  localparam logic [31:0] COUNT_MAX = 32'hFFFF_FFFF;
  localparam logic [7:0] LENGTH_MAX = 8'hFF;

  localparam logic CMD_DATA = 1'b0;
  localparam logic CMD_EOF = 1'b1;
  localparam logic KIND_LINE = 1'b0;
  localparam logic KIND_SUMMARY = 1'b1;

  typedef enum logic [2:0] {
    REG_PATTERN_LOW = 3'd0,
    REG_PATTERN_HIGH = 3'd1,
    REG_PATTERN_LENGTH = 3'd2,
    REG_IGNORE_CASE = 3'd3,
    REG_INVERT = 3'd4
  } reg_index_t;

  typedef struct packed {
    logic        kind;
    logic [31:0] line_number;
    logic [7:0]  line_length;
    logic        selected;
    logic [31:0] selected_count;
    logic        last;
  } result_t;

  // ASCII case folding of upper-case letters when enabled.
  function automatic logic [7:0] fold(input logic [7:0] c, input logic en);
    logic [7:0] r;
    r = c;
    if (en && c >= 8'h41 && c <= 8'h5A) begin
      r = c + 8'd32;
    end
    return r;
  endfunction

endpackage

>>> sv/lsf_ifs.sv
`timescale 1ns / 1ps
// Channel interfaces of the line substring filter: byte stream, report
// stream and configuration write channel.
interface lsf_stream_if;
  logic       valid;
  logic       ready;
  logic       cmd;
  logic [7:0] data_byte;
  modport source(output valid, cmd, data_byte, input ready);
  modport sink(input valid, cmd, data_byte, output ready);
endinterface

interface lsf_report_if;
  logic        valid;
  logic        ready;
  logic        kind;
  logic [31:0] line_number;
  logic [7:0]  line_length;
  logic        selected;
  logic [31:0] selected_count;
  logic        last;
  modport source(output valid, kind, line_number, line_length, selected,
                 selected_count, last, input ready);
  modport sink(input valid, kind, line_number, line_length, selected,
               selected_count, last, output ready);
endinterface

interface lsf_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [63:0] data;
  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface

>>> sv/lsf_cell.sv
`timescale 1ns / 1ps
// One cell of the match window: holds one recent line byte and compares the
// byte it takes in against its pattern byte. Depends on lsf_pkg.
module lsf_cell (
  input  logic       clk,
  input  logic       shift,
  input  logic [7:0] byte_from_prev,
  input  logic [7:0] pattern_byte,
  input  logic       ignore_case,
  input  logic       active,
  output logic [7:0] byte_held,
  output logic       hit
);
  import lsf_pkg::*;

  // The comparison sees the byte this cell holds after the shift.
  assign hit = !active ||
               (fold(byte_from_prev, ignore_case) == fold(pattern_byte, ignore_case));

  always_ff @(posedge clk) begin
    if (shift) begin
      byte_held <= byte_from_prev;
    end
  end

endmodule

>>> sv/lsf_result_queue.sv
`timescale 1ns / 1ps
// Three-entry result queue that drives the report channel. It takes one or two
// results in a beat and tells the input side when two slots are free.
// Depends on lsf_pkg and lsf_ifs.
module lsf_result_queue (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic             push_two,
  input  lsf_pkg::result_t item_a,
  input  lsf_pkg::result_t item_b,
  output logic             room,
  lsf_report_if.source     report
);
  import lsf_pkg::*;

  result_t    slot [3];
  result_t    slot_next [3];
  logic [1:0] count;
  logic [1:0] count_next;
  logic [1:0] fill;
  logic       pop;

  assign pop = report.valid && report.ready;
  // At most one result left after this cycle's pop leaves room for two more.
  assign room = (count <= 2'd1) || (count == 2'd2 && pop);

  assign report.valid = (count != 2'd0);
  assign report.kind = slot[0].kind;
  assign report.line_number = slot[0].line_number;
  assign report.line_length = slot[0].line_length;
  assign report.selected = slot[0].selected;
  assign report.selected_count = slot[0].selected_count;
  assign report.last = slot[0].last;

  always_comb begin
    slot_next[0] = slot[0];
    slot_next[1] = slot[1];
    slot_next[2] = slot[2];
    fill = count;
    if (pop) begin
      slot_next[0] = slot[1];
      slot_next[1] = slot[2];
      fill = count - 2'd1;
    end
    // A push only happens when at most one entry is left after the pop.
    if (push) begin
      if (fill == 2'd0) begin
        slot_next[0] = item_a;
        slot_next[1] = item_b;
      end else begin
        slot_next[1] = item_a;
        slot_next[2] = item_b;
      end
    end
    count_next = fill + (push ? (push_two ? 2'd2 : 2'd1) : 2'd0);
  end

  always_ff @(posedge clk) begin
    slot[0] <= slot_next[0];
    slot[1] <= slot_next[1];
    slot[2] <= slot_next[2];
    if (rst) begin
      count <= 2'd0;
    end else begin
      count <= count_next;
    end
  end

endmodule

>>> sv/line_substring_filter_top.sv
`timescale 1ns / 1ps
// Top level of the line substring filter: configuration registers, line
// state, the chain of window cells and the result queue.
// Depends on lsf_pkg, lsf_ifs, lsf_cell and lsf_result_queue.

// The block takes one byte beat per clock cycle while ready and cuts the
// stream into lines; a line ends at a newline (which counts in its length)
// or once LINE_MAX-1 bytes have arrived. Each finished line gives one report
// beat with its number, length and selected flag through the result queue.
// An end-of-file beat gives the flushed partial line, if any, and then the
// file summary, after which the line number and selected count start over.
// Matching runs in a row of PATTERN_MAX cells that shift the recent bytes
// along by one position per byte, so a byte is compared in the cycle it is
// accepted. Results wait in a three-entry queue; the stream side is ready
// whenever at most one result is left in it after the current report beat,
// which keeps one byte per cycle, end-of-file beats with two results included,
// while the report side keeps up.
// The configuration channel is always ready and should only be written while
// the block is idle; a write to an index past the register list is ignored.
module line_substring_filter_top #(
  parameter int PATTERN_MAX = 16,
  parameter int LINE_MAX = 256
) (
  input  logic         clk,
  input  logic         rst,
  lsf_stream_if.sink   stream,
  lsf_report_if.source report,
  lsf_cfg_if.sink      cfg
);
  import lsf_pkg::*;

  localparam logic [7:0] LINE_LIMIT = 8'(LINE_MAX - 1);
  localparam logic [4:0] LEN_CAP = 5'(PATTERN_MAX);

  // Configuration registers.
  logic [63:0] pattern_low;
  logic [63:0] pattern_high;
  logic [4:0]  pattern_length;
  logic        ignore_case;
  logic        invert;

  // Per-line and per-file state.
  logic [7:0]  bytes_in_line;
  logic [7:0]  bytes_before_zero;
  logic        zero_seen;
  logic        pattern_found;
  logic [31:0] lines_so_far;
  logic [31:0] selected_so_far;

  logic [127:0] pattern;
  logic [4:0]   used_length;
  logic         accept;
  logic         is_eof;
  logic         shift;
  logic         window_match;
  logic [7:0]   cell_byte [PATTERN_MAX];
  logic [PATTERN_MAX-1:0] cell_hit;

  logic        room;
  logic        push;
  logic        push_two;
  result_t     item_a;
  result_t     item_b;
  result_t     line_item;
  result_t     summary_item;

  logic [7:0]  bytes_in_line_next;
  logic [7:0]  bytes_before_zero_next;
  logic        found_now;
  logic        line_found;
  logic        line_selected;
  logic [31:0] lines_inc;
  logic [31:0] selected_inc;
  logic        line_done;
  logic        has_partial;

  assign pattern = {pattern_high, pattern_low};
  assign used_length = (pattern_length > LEN_CAP) ? LEN_CAP : pattern_length;

  assign stream.ready = room;
  assign accept = stream.valid && stream.ready;
  assign is_eof = (stream.cmd == CMD_EOF);

  // Bytes before the first zero byte of a line enter the window.
  assign shift = accept && !is_eof && !zero_seen && (stream.data_byte != 8'd0);

  // Configuration writes.
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      pattern_low <= '0;
      pattern_high <= '0;
      pattern_length <= '0;
      ignore_case <= 1'b0;
      invert <= 1'b0;
    end else if (cfg.valid && cfg.ready) begin
      case (cfg.index)
        REG_PATTERN_LOW: pattern_low <= cfg.data;
        REG_PATTERN_HIGH: pattern_high <= cfg.data;
        REG_PATTERN_LENGTH: pattern_length <= cfg.data[4:0];
        REG_IGNORE_CASE: ignore_case <= cfg.data[0];
        REG_INVERT: invert <= cfg.data[0];
        default: begin
        end
      endcase
    end
  end

  // Window cells. Cell i holds the byte i places back from the newest one and
  // is compared against pattern byte used_length-1-i.
  for (genvar i = 0; i < PATTERN_MAX; i++) begin : g_cell
    logic [7:0] byte_from_prev;
    logic [3:0] pattern_index;
    logic       active;

    if (i == 0) begin : g_head
      assign byte_from_prev = stream.data_byte;
    end else begin : g_body
      assign byte_from_prev = cell_byte[i-1];
    end

    assign pattern_index = 4'(used_length - 5'(i) - 5'd1);
    assign active = (5'(i) < used_length);

    lsf_cell u_cell (
      .clk            (clk),
      .shift          (shift),
      .byte_from_prev (byte_from_prev),
      .pattern_byte   (pattern[pattern_index*8 +: 8]),
      .ignore_case    (ignore_case),
      .active         (active),
      .byte_held      (cell_byte[i]),
      .hit            (cell_hit[i])
    );
  end

  assign bytes_before_zero_next = (bytes_before_zero == LENGTH_MAX) ?
                                  bytes_before_zero : bytes_before_zero + 8'd1;
  assign bytes_in_line_next = (bytes_in_line == LENGTH_MAX) ?
                              bytes_in_line : bytes_in_line + 8'd1;

  // The window only counts once enough real bytes of the line are in it.
  assign window_match = (&cell_hit) && (used_length != 5'd0) &&
                        (bytes_before_zero_next >= {3'b000, used_length});

  assign found_now = pattern_found || (shift && window_match);
  assign line_found = (is_eof ? pattern_found : found_now) || (used_length == 5'd0);
  assign line_selected = line_found != invert;

  assign lines_inc = (lines_so_far == COUNT_MAX) ? lines_so_far : lines_so_far + 32'd1;
  assign selected_inc = (line_selected && selected_so_far != COUNT_MAX) ?
                        selected_so_far + 32'd1 : selected_so_far;

  assign line_done = (stream.data_byte == NEWLINE) || (bytes_in_line_next >= LINE_LIMIT);
  assign has_partial = (bytes_in_line != 8'd0);

  always_comb begin
    line_item.kind = KIND_LINE;
    line_item.line_number = lines_inc;
    line_item.line_length = is_eof ? bytes_in_line : bytes_in_line_next;
    line_item.selected = line_selected;
    line_item.selected_count = selected_inc;
    line_item.last = !is_eof;

    summary_item.kind = KIND_SUMMARY;
    summary_item.line_number = has_partial ? lines_inc : lines_so_far;
    summary_item.line_length = 8'd0;
    summary_item.selected = 1'b0;
    summary_item.selected_count = has_partial ? selected_inc : selected_so_far;
    summary_item.last = 1'b1;

    push = 1'b0;
    push_two = 1'b0;
    item_a = line_item;
    item_b = summary_item;
    if (accept) begin
      if (is_eof) begin
        push = 1'b1;
        push_two = has_partial;
        if (!has_partial) begin
          item_a = summary_item;
        end
      end else begin
        push = line_done;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bytes_in_line <= '0;
      bytes_before_zero <= '0;
      zero_seen <= 1'b0;
      pattern_found <= 1'b0;
      lines_so_far <= '0;
      selected_so_far <= '0;
    end else if (accept) begin
      if (is_eof) begin
        bytes_in_line <= '0;
        bytes_before_zero <= '0;
        zero_seen <= 1'b0;
        pattern_found <= 1'b0;
        lines_so_far <= '0;
        selected_so_far <= '0;
      end else if (line_done) begin
        bytes_in_line <= '0;
        bytes_before_zero <= '0;
        zero_seen <= 1'b0;
        pattern_found <= 1'b0;
        lines_so_far <= lines_inc;
        selected_so_far <= selected_inc;
      end else begin
        bytes_in_line <= bytes_in_line_next;
        if (shift) begin
          bytes_before_zero <= bytes_before_zero_next;
        end
        if (!zero_seen && stream.data_byte == 8'd0) begin
          zero_seen <= 1'b1;
        end
        pattern_found <= found_now;
      end
    end
  end

  lsf_result_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_two (push_two),
    .item_a   (item_a),
    .item_b   (item_b),
    .room     (room),
    .report   (report)
  );

endmodule

>>> tb/sv/lsf_checker.sv
`timescale 1ns / 1ps
// Scoreboard of the line substring filter: watches the byte, report and
// configuration channels, predicts every report and compares it on arrival.
// Depends on lsf_pkg and the channel interfaces of lsf_ifs.
module lsf_checker #(
  parameter int PATTERN_MAX = 16,
  parameter int LINE_MAX = 256
) (
  input  logic   clk,
  input  logic   rst,
  lsf_stream_if  stream,
  lsf_report_if  report,
  lsf_cfg_if     cfg,
  output int     fail_count,
  output int     pending_count,
  output int     line_reports,
  output int     file_summaries
);
  import lsf_pkg::*;

  // Shadow copy of the configuration registers.
  logic [63:0] pat_lo, pat_hi;
  logic [4:0]  pat_len;
  logic        fold_en, invert_en;

  // Per-line and per-file state of the predicted block.
  logic [7:0]  recent [PATTERN_MAX];
  logic [7:0]  line_bytes;
  logic [7:0]  clean_bytes;
  logic        zero_hit;
  logic        found;
  logic [31:0] line_count;
  logic [31:0] sel_count;

  result_t     expected_reports [$];

  function automatic logic [7:0] case_folded(input logic [7:0] c);
    if (fold_en && c >= "A" && c <= "Z") begin
      return c + 8'd32;
    end
    return c;
  endfunction

  function automatic int active_length();
    return (pat_len > PATTERN_MAX) ? PATTERN_MAX : int'(pat_len);
  endfunction

  function automatic logic window_hit();
    int n;
    logic [7:0] pb;
    n = active_length();
    if (n == 0 || int'(clean_bytes) < n) begin
      return 1'b0;
    end
    for (int i = 0; i < n; i++) begin
      pb = (i < 8) ? pat_lo[8*i +: 8] : pat_hi[8*(i-8) +: 8];
      if (case_folded(pb) != case_folded(recent[n-1-i])) begin
        return 1'b0;
      end
    end
    return 1'b1;
  endfunction

  task automatic clear_line();
    for (int i = 0; i < PATTERN_MAX; i++) begin
      recent[i] = 8'h00;
    end
    line_bytes = 8'd0;
    clean_bytes = 8'd0;
    zero_hit = 1'b0;
    found = 1'b0;
  endtask

  task automatic close_line(input logic is_last);
    result_t r;
    logic sel;
    sel = (found || active_length() == 0) != invert_en;
    if (line_count != COUNT_MAX) begin
      line_count++;
    end
    if (sel && sel_count != COUNT_MAX) begin
      sel_count++;
    end
    r.kind = KIND_LINE;
    r.line_number = line_count;
    r.line_length = line_bytes;
    r.selected = sel;
    r.selected_count = sel_count;
    r.last = is_last;
    expected_reports.push_back(r);
    clear_line();
  endtask

  task automatic take_beat(input logic c, input logic [7:0] b);
    result_t r;
    if (c == CMD_EOF) begin
      if (line_bytes != 8'd0) begin
        close_line(1'b0);
      end
      r.kind = KIND_SUMMARY;
      r.line_number = line_count;
      r.line_length = 8'd0;
      r.selected = 1'b0;
      r.selected_count = sel_count;
      r.last = 1'b1;
      expected_reports.push_back(r);
      clear_line();
      line_count = 32'd0;
      sel_count = 32'd0;
    end else begin
      if (!zero_hit) begin
        if (b == 8'h00) begin
          zero_hit = 1'b1;
        end else begin
          for (int i = PATTERN_MAX - 1; i > 0; i--) begin
            recent[i] = recent[i-1];
          end
          recent[0] = b;
          if (clean_bytes != LENGTH_MAX) begin
            clean_bytes++;
          end
          if (window_hit()) begin
            found = 1'b1;
          end
        end
      end
      if (line_bytes != LENGTH_MAX) begin
        line_bytes++;
      end
      if (b == NEWLINE || int'(line_bytes) >= LINE_MAX - 1) begin
        close_line(1'b1);
      end
    end
  endtask

  task automatic apply_write(input logic [2:0] idx, input logic [63:0] v);
    case (reg_index_t'(idx))
      REG_PATTERN_LOW: pat_lo = v;
      REG_PATTERN_HIGH: pat_hi = v;
      REG_PATTERN_LENGTH: pat_len = v[4:0];
      REG_IGNORE_CASE: fold_en = v[0];
      REG_INVERT: invert_en = v[0];
      default: ;
    endcase
  endtask

  task automatic check_report();
    result_t got, want;
    got.kind = report.kind;
    got.line_number = report.line_number;
    got.line_length = report.line_length;
    got.selected = report.selected;
    got.selected_count = report.selected_count;
    got.last = report.last;
    if (expected_reports.size() == 0) begin
      fail_count++;
      if (fail_count <= 10) begin
        $display("%0t: unexpected report: kind=%0d line=%0d len=%0d sel=%0d cnt=%0d last=%0d",
                 $time, got.kind, got.line_number, got.line_length, got.selected,
                 got.selected_count, got.last);
      end
    end else begin
      want = expected_reports.pop_front();
      if (got.kind !== want.kind || got.line_number !== want.line_number ||
          got.line_length !== want.line_length || got.selected !== want.selected ||
          got.selected_count !== want.selected_count || got.last !== want.last) begin
        fail_count++;
        if (fail_count <= 10) begin
          $display("%0t: expected kind=%0d line=%0d len=%0d sel=%0d cnt=%0d last=%0d",
                   $time, want.kind, want.line_number, want.line_length, want.selected,
                   want.selected_count, want.last);
          $display("%0t:      got kind=%0d line=%0d len=%0d sel=%0d cnt=%0d last=%0d",
                   $time, got.kind, got.line_number, got.line_length, got.selected,
                   got.selected_count, got.last);
        end
      end
    end
    if (got.kind === KIND_SUMMARY) begin
      file_summaries++;
    end else begin
      line_reports++;
    end
  endtask

  // Outputs of the block reach the report channel through its registered result
  // queue, so a report taken at this edge always belongs to an earlier beat.
  always @(posedge clk) begin
    if (rst) begin
      pat_lo = 64'd0;
      pat_hi = 64'd0;
      pat_len = 5'd0;
      fold_en = 1'b0;
      invert_en = 1'b0;
      clear_line();
      line_count = 32'd0;
      sel_count = 32'd0;
      expected_reports.delete();
      fail_count = 0;
      line_reports = 0;
      file_summaries = 0;
    end else begin
      if (report.valid && report.ready) begin
        check_report();
      end
      if (cfg.valid && cfg.ready) begin
        apply_write(cfg.index, cfg.data);
      end
      if (stream.valid && stream.ready) begin
        take_beat(stream.cmd, stream.data_byte);
      end
    end
    pending_count = expected_reports.size();
  end

endmodule

>>> tb/sv/tb_top.sv
`timescale 1ns / 1ps
// Top of the line substring filter testbench: clock, reset, stimulus, report
// back-pressure, watchdog and verdict. Depends on lsf_pkg, lsf_ifs, lsf_checker
// and the block's top level.
module tb_top;
  import lsf_pkg::*;

  localparam int PATTERN_MAX = 16;
  localparam int LINE_MAX = 256;
  // The longest quiet stretch of a correct run is a byte gap followed by two
  // report stalls.
  localparam int QUIET_LIMIT = 1000;
  localparam int ITEM_TARGET = 900;

  logic clk = 1'b0;
  logic rst;

  lsf_stream_if stream_ch ();
  lsf_report_if report_ch ();
  lsf_cfg_if    cfg_ch ();

  int fail_count;
  int pending_count;
  int line_reports;
  int file_summaries;

  // Pacing knobs: the largest byte gap and report stall drawn per beat. A
  // phase with both at zero runs the block at full rate.
  int gap_max = 0;
  int stall_max = 0;
  int stall_draw;
  int hold_cycles;
  int quiet_cycles;
  int items_sent;
  int configs_loaded;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  line_substring_filter_top #(
    .PATTERN_MAX(PATTERN_MAX),
    .LINE_MAX(LINE_MAX)
  ) dut (
    .clk(clk),
    .rst(rst),
    .stream(stream_ch),
    .report(report_ch),
    .cfg(cfg_ch)
  );

  lsf_checker #(
    .PATTERN_MAX(PATTERN_MAX),
    .LINE_MAX(LINE_MAX)
  ) u_checker (
    .clk(clk),
    .rst(rst),
    .stream(stream_ch),
    .report(report_ch),
    .cfg(cfg_ch),
    .fail_count(fail_count),
    .pending_count(pending_count),
    .line_reports(line_reports),
    .file_summaries(file_summaries)
  );

  // Report side back-pressure. After each accepted report beat the sink draws
  // a random stall, bounded by stall_max, during which ready stays low.
  always @(posedge clk) begin
    if (rst) begin
      report_ch.ready <= 1'b0;
      hold_cycles <= 0;
    end else if (report_ch.ready) begin
      if (report_ch.valid) begin
        stall_draw = $urandom_range(0, stall_max);
        if (stall_draw > 0) begin
          report_ch.ready <= 1'b0;
          hold_cycles <= stall_draw - 1;
        end
      end
    end else if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
    end else begin
      report_ch.ready <= 1'b1;
    end
  end

  // The watchdog restarts on every beat of any channel. A run that stops
  // making progress, including one that leaves predicted reports behind,
  // ends here.
  always @(posedge clk) begin
    if (rst || (stream_ch.valid && stream_ch.ready) ||
        (report_ch.valid && report_ch.ready) || (cfg_ch.valid && cfg_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("Watchdog: no beat for %0d cycles, %0d reports still predicted.",
               QUIET_LIMIT, pending_count);
      $display("*** FAILED ***");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Sends one beat on the byte channel. Send tasks are entered right after a
  // rising edge and return at the edge where the beat was accepted, so valid
  // stays high across back-to-back beats with a single assignment per edge.
  task automatic send_beat(input logic c, input logic [7:0] b);
    int gap;
    gap = $urandom_range(0, gap_max);
    if (gap > 0) begin
      stream_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    stream_ch.valid <= 1'b1;
    stream_ch.cmd <= c;
    stream_ch.data_byte <= b;
    @(posedge clk);
    while (!stream_ch.ready) @(posedge clk);
    items_sent++;
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) begin
      send_beat(CMD_DATA, s[i]);
    end
  endtask

  // Drops valid and waits until every predicted report has arrived. A data
  // byte that ends no line leaves nothing to wait for, so the task then waits
  // on to let the block settle before the registers change.
  task automatic wait_idle();
    stream_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic put_reg(input reg_index_t idx, input logic [63:0] v);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data <= v;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
  endtask

  // Writes all five registers back to back, then releases the channel.
  task automatic load_config(input logic [63:0] lo, input logic [63:0] hi,
                             input logic [4:0] len, input logic ic, input logic inv);
    put_reg(REG_PATTERN_LOW, lo);
    put_reg(REG_PATTERN_HIGH, hi);
    put_reg(REG_PATTERN_LENGTH, {59'd0, len});
    put_reg(REG_IGNORE_CASE, {63'd0, ic});
    put_reg(REG_INVERT, {63'd0, inv});
    cfg_ch.valid <= 1'b0;
    configs_loaded++;
  endtask

  // Letters from a tiny alphabet, so that random lines hit short patterns often.
  function automatic logic [7:0] pick_letter();
    case ($urandom_range(0, 4))
      0: return "a";
      1: return "b";
      2: return "A";
      3: return "B";
      default: return "x";
    endcase
  endfunction

  function automatic int pick_pace();
    case ($urandom_range(0, 2))
      0: return 0;
      1: return 3;
      default: return 15;
    endcase
  endfunction

  // One random phase: a fresh register setting, a handful of lines and
  // usually an end of file. Most lines are well formed text that may carry
  // the pattern; the rest are raw noise or long runs of text that may be cut at
  // the length limit. A phase that ends without an end of file may leave a
  // partial line behind, so the next setting takes effect in mid-line.
  task automatic run_random_phase();
    logic [7:0]  pat [PATTERN_MAX];
    logic [63:0] lo, hi;
    logic [4:0]  len;
    logic        ic, inv;
    logic [7:0]  c;
    int          flavor, used, nlines, style, nbytes;
    flavor = $urandom_range(0, 9);
    case (flavor)
      0: len = 5'd0;
      1: len = 5'($urandom_range(17, 31));
      2, 3: len = 5'd16;
      default: len = 5'($urandom_range(1, 6));
    endcase
    used = (len > PATTERN_MAX) ? PATTERN_MAX : int'(len);
    for (int k = 0; k < PATTERN_MAX; k++) begin
      if (flavor == 3) begin
        pat[k] = 8'($urandom_range(0, 255));
      end else if (flavor == 4) begin
        pat[k] = 8'hFF;
      end else begin
        pat[k] = pick_letter();
      end
    end
    for (int k = 0; k < 8; k++) begin
      lo[8*k +: 8] = pat[k];
      hi[8*k +: 8] = pat[k+8];
    end
    ic = 1'($urandom_range(0, 1));
    inv = 1'($urandom_range(0, 1));
    gap_max = pick_pace();
    stall_max = pick_pace();
    wait_idle();
    load_config(lo, hi, len, ic, inv);

    nlines = $urandom_range(1, 8);
    for (int n = 0; n < nlines; n++) begin
      style = $urandom_range(0, 19);
      if (style == 0) begin
        // Long run of text, cut by the block once the line is full.
        nbytes = $urandom_range(250, 300);
        for (int i = 0; i < nbytes; i++) begin
          send_beat(CMD_DATA, pick_letter());
        end
      end else if (style <= 3) begin
        nbytes = $urandom_range(0, 20);
        for (int i = 0; i < nbytes; i++) begin
          send_beat(CMD_DATA, 8'($urandom_range(0, 255)));
        end
      end else begin
        nbytes = $urandom_range(0, 8);
        for (int i = 0; i < nbytes; i++) begin
          send_beat(CMD_DATA, pick_letter());
        end
        // A zero byte here hides whatever follows from the matcher.
        if ($urandom_range(0, 7) == 0) begin
          send_beat(CMD_DATA, 8'h00);
        end
        if ($urandom_range(0, 1) == 1) begin
          for (int k = 0; k < used; k++) begin
            c = pat[k];
            if (ic && (c | 8'h20) >= "a" && (c | 8'h20) <= "z" &&
                $urandom_range(0, 1) == 1) begin
              c = c ^ 8'h20;
            end
            send_beat(CMD_DATA, c);
          end
        end
        nbytes = $urandom_range(0, 8);
        for (int i = 0; i < nbytes; i++) begin
          send_beat(CMD_DATA, pick_letter());
        end
        send_beat(CMD_DATA, NEWLINE);
      end
    end
    // The byte field of an end-of-file beat carries noise; the block ignores it.
    if ($urandom_range(0, 3) != 0) begin
      send_beat(CMD_EOF, 8'($urandom_range(0, 255)));
    end
  endtask

  initial begin
    rst = 1'b1;
    stream_ch.valid = 1'b0;
    stream_ch.cmd = CMD_DATA;
    stream_ch.data_byte = 8'h00;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = REG_PATTERN_LOW;
    cfg_ch.data = 64'd0;
    items_sent = 0;
    configs_loaded = 0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Registers still at reset: the pattern is empty, so every line matches.
    // An empty file gives a bare summary, a line that starts with a zero byte
    // still matches, and an end of file after a partial line flushes it
    // ahead of the summary.
    send_beat(CMD_EOF, 8'h00);
    send_beat(CMD_DATA, 8'h00);
    send_beat(CMD_DATA, NEWLINE);
    send_beat(CMD_DATA, 8'hFF);
    send_beat(CMD_EOF, 8'hFF);

    // Pattern "ab" with case folding: the upper-case line matches, while a
    // zero byte between the letters keeps the second line from matching.
    wait_idle();
    load_config(64'h6261, 64'hFFFF_FFFF_FFFF_FFFF, 5'd2, 1'b1, 1'b0);
    send_text("xAB\n");
    send_beat(CMD_DATA, "a");
    send_beat(CMD_DATA, 8'h00);
    send_text("b\n");
    send_beat(CMD_EOF, 8'h00);

    // A zero byte inside the pattern can never match; with invert set the
    // line is selected.
    wait_idle();
    load_config(64'h62_00_61, 64'd0, 5'd3, 1'b0, 1'b1);
    send_beat(CMD_DATA, "a");
    send_beat(CMD_DATA, 8'h00);
    send_text("b\n");
    send_beat(CMD_EOF, 8'h00);

    // Length beyond the window, all bytes 0xFF: clamped to sixteen bytes and
    // not found in a short line. Then a partial line gets a new pattern in
    // mid-line, which applies from the next byte on.
    wait_idle();
    load_config(64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 5'd31, 1'b0, 1'b0);
    send_text("q\n");
    send_beat(CMD_DATA, "a");
    wait_idle();
    load_config(64'h61, 64'd0, 5'd1, 1'b0, 1'b0);
    send_text("a\n");
    send_beat(CMD_EOF, 8'h00);

    while (items_sent < ITEM_TARGET) begin
      run_random_phase();
    end

    // Drain, then keep the clock running to show any stray report.
    wait_idle();
    repeat (8) @(posedge clk);

    $display("Sent %0d stream beats under %0d register settings.", items_sent, configs_loaded);
    $display("Checked %0d line reports and %0d file summaries, %0d mismatches.",
             line_reports, file_summaries, fail_count);
    if (fail_count == 0 && pending_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

>>> filelist.f
sv/lsf_pkg.sv
sv/lsf_ifs.sv
sv/lsf_cell.sv
sv/lsf_result_queue.sv
sv/line_substring_filter_top.sv
tb/sv/lsf_checker.sv
tb/sv/tb_top.sv
